[hdl/manchester_bit_fifo_assert.svh]
// assertion macros for the manchester bit fifo checker
// expects clk and rst to be visible where the macros are used
`ifndef MANCHESTER_BIT_FIFO_ASSERT_SVH
`define MANCHESTER_BIT_FIFO_ASSERT_SVH

// same-cycle implication, switched off during reset
`define MBF_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, switched off during reset
`define MBF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/mbf_pkg.sv]
// shared types, codes and the manchester expansion for the bit fifo
// no dependencies; imported by every module of the block
package mbf_pkg;

  // default store size in symbols, a power of two from 32 to 65536
  localparam int unsigned FIFO_SIZE_DEF = 2048;

  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned SYM_PER_BYTE = 2 * BYTE_W;
  localparam int unsigned SYM_SHIFT    = 4;
  localparam int unsigned FILL_W       = 11;

  // operation codes
  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_POP   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NO_ROOM = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [BYTE_W-1:0] data_byte;
  } op_word_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              line_bit;
    logic [FILL_W-1:0] fill_count;
  } rsp_word_t;

  // what the index control hands to the response register
  typedef struct packed {
    logic [1:0]        status;
    logic              pop_ok;
    logic [FILL_W-1:0] fill;
  } res_info_t;

  // msb first, a one becomes 1 then 0, a zero becomes 0 then 1;
  // bit j of the result is the symbol at head plus j
  function automatic logic [SYM_PER_BYTE-1:0] manchester_expand(
    input logic [BYTE_W-1:0] b
  );
    logic [SYM_PER_BYTE-1:0] s;
    s = '0;
    for (int k = 0; k < BYTE_W; k++) begin
      s[2*k]   = b[BYTE_W-1-k];
      s[2*k+1] = ~b[BYTE_W-1-k];
    end
    return s;
  endfunction

endpackage

[hdl/mbf_store.sv]
// symbol store: rows of sixteen symbols, one row written per push,
// one symbol read per pop with registered read data; uses mbf_pkg
module mbf_store #(
  parameter int unsigned FIFO_SIZE_BITS = mbf_pkg::FIFO_SIZE_DEF,
  localparam int unsigned IdxW = $clog2(FIFO_SIZE_BITS),
  localparam int unsigned RowW = IdxW - mbf_pkg::SYM_SHIFT
) (
  input  logic                              clk,
  input  logic                              wr_en,
  input  logic [RowW-1:0]                   wr_row,
  input  logic [mbf_pkg::SYM_PER_BYTE-1:0]  wr_data,
  input  logic                              rd_en,
  input  logic [IdxW-1:0]                   rd_idx,
  output logic                              rd_bit
);
  import mbf_pkg::*;

  localparam int unsigned Rows = FIFO_SIZE_BITS / SYM_PER_BYTE;

  logic [SYM_PER_BYTE-1:0] mem [Rows];
  logic [SYM_PER_BYTE-1:0] rd_data;
  logic [SYM_SHIFT-1:0]    rd_off;

  // one row write and one row read per cycle, read data registered
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_row] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_idx[IdxW-1:SYM_SHIFT]];
      rd_off  <= rd_idx[SYM_SHIFT-1:0];
    end
  end

  // pick the symbol out of the registered row
  assign rd_bit = rd_data[rd_off];

endmodule

[hdl/mbf_ctrl.sv]
// head and tail indices, room and empty checks, fill after each word
// uses mbf_pkg; drives the store ports of mbf_store
module mbf_ctrl #(
  parameter int unsigned FIFO_SIZE_BITS = mbf_pkg::FIFO_SIZE_DEF,
  localparam int unsigned IdxW = $clog2(FIFO_SIZE_BITS),
  localparam int unsigned RowW = IdxW - mbf_pkg::SYM_SHIFT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              accept,
  input  mbf_pkg::op_word_t                 op,
  output logic                              wr_en,
  output logic [RowW-1:0]                   wr_row,
  output logic [mbf_pkg::SYM_PER_BYTE-1:0]  wr_data,
  output logic                              rd_en,
  output logic [IdxW-1:0]                   rd_idx,
  output mbf_pkg::res_info_t                info
);
  import mbf_pkg::*;

  logic [IdxW-1:0]        wr_idx;
  logic [IdxW-1:0]        wr_idx_next;
  logic [IdxW-1:0]        rd_idx_q;
  logic [IdxW-1:0]        rd_idx_next;
  logic [IdxW-1:0]        free_cnt;
  logic [IdxW-1:0]        held_next;
  logic [IdxW+FILL_W-1:0] held_ext;
  logic                   push_ok;
  logic                   pop_ok;
  logic [1:0]             status;

  // the head only moves in steps of sixteen, so pushes fill whole rows
  assign free_cnt = rd_idx_q - wr_idx - IdxW'(1);

  // decode the word and work out the next indices
  always_comb begin
    wr_idx_next = wr_idx;
    rd_idx_next = rd_idx_q;
    push_ok     = 1'b0;
    pop_ok      = 1'b0;
    status      = ST_DONE;
    unique case (op.opcode)
      OP_PUSH: begin
        if (free_cnt < IdxW'(SYM_PER_BYTE)) begin
          status = ST_NO_ROOM;
        end else begin
          push_ok     = 1'b1;
          wr_idx_next = wr_idx + IdxW'(SYM_PER_BYTE);
        end
      end
      OP_POP: begin
        if (wr_idx == rd_idx_q) begin
          status = ST_EMPTY;
        end else begin
          pop_ok      = 1'b1;
          rd_idx_next = rd_idx_q + IdxW'(1);
        end
      end
      OP_CLEAR: begin
        wr_idx_next = '0;
        rd_idx_next = '0;
      end
      default: begin
      end
    endcase
  end

  // fill after the operation, cut or widened to the reported width
  assign held_next = wr_idx_next - rd_idx_next;
  assign held_ext  = {{FILL_W{1'b0}}, held_next};

  assign info.status = status;
  assign info.pop_ok = pop_ok;
  assign info.fill   = held_ext[FILL_W-1:0];

  // store access
  assign wr_en   = accept & push_ok;
  assign wr_row  = wr_idx[IdxW-1:SYM_SHIFT];
  assign wr_data = manchester_expand(op.data_byte);
  assign rd_en   = accept & pop_ok;
  assign rd_idx  = rd_idx_q;

  // index registers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx   <= '0;
      rd_idx_q <= '0;
    end else if (accept) begin
      wr_idx   <= wr_idx_next;
      rd_idx_q <= rd_idx_next;
    end
  end

endmodule

[hdl/manchester_bit_fifo.sv]
// channel  | valid     | stall     | word
// ---------+-----------+-----------+----------------------------------
// op       | op_valid  | op_stall  | op_word  (opcode, data_byte)
// rsp      | rsp_valid | rsp_stall | rsp_word (status, line_bit, fill_count)
//
// one word per cycle while no held response stalls op; its response shows in the cycle after
// acceptance, from the response register and the store read register.
// reset clears both indices at once; store contents are left as they are,
// since no symbol is read before a push has written it.
// op_stall is high while a response is held by rsp_stall.
// top level of the manchester bit fifo; uses mbf_pkg, mbf_ctrl, mbf_store
module manchester_bit_fifo #(
  parameter int unsigned FIFO_SIZE_BITS = mbf_pkg::FIFO_SIZE_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               op_valid,
  output logic               op_stall,
  input  mbf_pkg::op_word_t  op_word,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output mbf_pkg::rsp_word_t rsp_word
);
  import mbf_pkg::*;

  localparam int unsigned IdxW = $clog2(FIFO_SIZE_BITS);
  localparam int unsigned RowW = IdxW - SYM_SHIFT;

  logic                    accept;
  logic                    wr_en;
  logic [RowW-1:0]         wr_row;
  logic [SYM_PER_BYTE-1:0] wr_data;
  logic                    rd_en;
  logic [IdxW-1:0]         rd_idx;
  logic                    rd_bit;
  res_info_t               info;
  res_info_t               info_q;

  // take a word whenever the response register is free or being emptied
  assign op_stall = rsp_valid & rsp_stall;
  assign accept   = op_valid & ~op_stall;

  mbf_ctrl #(
    .FIFO_SIZE_BITS(FIFO_SIZE_BITS)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .op     (op_word),
    .wr_en  (wr_en),
    .wr_row (wr_row),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_idx (rd_idx),
    .info   (info)
  );

  mbf_store #(
    .FIFO_SIZE_BITS(FIFO_SIZE_BITS)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_row (wr_row),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_idx (rd_idx),
    .rd_bit (rd_bit)
  );

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      info_q <= info;
    end
  end

  // the popped symbol arrives from the store read register
  assign rsp_word.status     = info_q.status;
  assign rsp_word.line_bit   = info_q.pop_ok & rd_bit;
  assign rsp_word.fill_count = info_q.fill;

endmodule

[hdl/mbf_checker.sv]
// port-level checks for the manchester bit fifo, bound to the top level
// uses mbf_pkg and the macros of manchester_bit_fifo_assert.svh
`include "manchester_bit_fifo_assert.svh"

module mbf_checker (
  input logic               clk,
  input logic               rst,
  input logic               op_valid,
  input logic               op_stall,
  input mbf_pkg::op_word_t  op_word,
  input logic               rsp_valid,
  input logic               rsp_stall,
  input mbf_pkg::rsp_word_t rsp_word
);
  import mbf_pkg::*;

  // every accepted word gives a response in the next cycle
  `MBF_ASSERT_NEXT(a_rsp_follows, op_valid && !op_stall, rsp_valid, "accepted word gave no response")

  // no word is taken while a response waits
  `MBF_ASSERT_IMPLIES(a_hold_input, rsp_valid && rsp_stall, op_stall, "word taken over a held response")

  // a symbol only comes out of a successful pop
  `MBF_ASSERT_IMPLIES(a_bit_on_done, rsp_valid && rsp_word.line_bit, rsp_word.status == ST_DONE, "line bit set on a failed operation")

  // a pop on empty leaves the fifo empty
  `MBF_ASSERT_IMPLIES(a_empty_fill, rsp_valid && rsp_word.status == ST_EMPTY, rsp_word.fill_count == '0, "empty pop with non-zero fill")

  // a held response keeps its word
  `MBF_ASSERT_NEXT(a_rsp_stable, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_word), "held response changed")

endmodule

bind manchester_bit_fifo mbf_checker u_mbf_checker (.*);

[tb/manchester_bit_fifo_tb.sv]
// self-checking testbench for the manchester bit fifo: directed words, then random traffic
// under four idle/stall patterns, each response checked against an in-bench bit model
// depends on mbf_pkg and the manchester_bit_fifo top level
module manchester_bit_fifo_tb;
  import mbf_pkg::*;

  localparam int unsigned DEPTH     = FIFO_SIZE_DEF;
  localparam logic [1:0]  OP_SPARE  = 2'd3;
  localparam int          RAND_WORDS = 435;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_HOLD} traffic_mix_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      op_valid = 1'b0;
  logic      op_stall;
  op_word_t  op_word = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  rsp_word_t rsp_word;

  // bit model of the fifo
  logic            line_store [DEPTH];
  logic [FILL_W-1:0] head_idx = '0;
  logic [FILL_W-1:0] tail_idx = '0;

  op_word_t  op_backlog  [$];
  rsp_word_t rsp_pending [$];

  logic         op_taken = 1'b0;
  int unsigned  idle_pct = 0;
  int unsigned  stall_pct = 0;
  traffic_mix_t cur_mix = MIX_FILL;
  int           mix_left = 200;
  int           errors = 0;
  int           n_checked = 0;
  int           n_pushed = 0, n_refused = 0, n_popped = 0, n_empty = 0, n_cleared = 0;

  manchester_bit_fifo DUT (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (op_valid),
    .op_stall  (op_stall),
    .op_word   (op_word),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_word  (rsp_word)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // apply one word to the model and give the response it should produce
  function automatic rsp_word_t apply_op(op_word_t w);
    rsp_word_t       r;
    logic [FILL_W-1:0] room;
    logic            b;
    int              k;
    r = '0;
    case (w.opcode)
      OP_PUSH: begin
        room = tail_idx - head_idx - 1'b1;
        if (room < SYM_PER_BYTE) begin
          r.status = ST_NO_ROOM;
          n_refused++;
        end else begin
          // msb first, one -> 1 0, zero -> 0 1
          for (k = 0; k < BYTE_W; k++) begin
            b = w.data_byte[BYTE_W-1-k];
            line_store[head_idx] = b;
            head_idx = head_idx + 1'b1;
            line_store[head_idx] = ~b;
            head_idx = head_idx + 1'b1;
          end
          n_pushed++;
        end
      end
      OP_POP: begin
        if (head_idx == tail_idx) begin
          r.status = ST_EMPTY;
          n_empty++;
        end else begin
          r.line_bit = line_store[tail_idx];
          tail_idx = tail_idx + 1'b1;
          n_popped++;
        end
      end
      OP_CLEAR: begin
        head_idx = '0;
        tail_idx = '0;
        n_cleared++;
      end
      default: ;
    endcase
    r.fill_count = head_idx - tail_idx;
    return r;
  endfunction

  // one random word, weighted by the current traffic mix
  function automatic op_word_t rand_op(traffic_mix_t m);
    op_word_t    w;
    int unsigned r;
    r = $urandom_range(99);
    w.data_byte = BYTE_W'($urandom_range(255));
    case (m)
      MIX_FILL:  w.opcode = (r < 86) ? OP_PUSH : (r < 98) ? OP_POP : OP_SPARE;
      MIX_DRAIN: w.opcode = (r < 3) ? OP_PUSH : (r < 91) ? OP_POP :
                            (r < 96) ? OP_CLEAR : OP_SPARE;
      default:   w.opcode = (r < 6) ? OP_PUSH : (r < 97) ? OP_POP :
                            (r < 98) ? OP_CLEAR : OP_SPARE;
    endcase
    return w;
  endfunction

  task automatic queue_op(logic [1:0] opc, logic [BYTE_W-1:0] data);
    op_word_t w;
    w.opcode    = opc;
    w.data_byte = data;
    op_backlog.push_back(w);
  endtask

  // random words in segments of a fixed mix, long fill runs reach a full fifo
  task automatic queue_random(int n);
    int i;
    for (i = 0; i < n; i++) begin
      if (mix_left == 0) begin
        cur_mix  = traffic_mix_t'($urandom_range(2));
        mix_left = $urandom_range(40, 200);
      end
      mix_left--;
      op_backlog.push_back(rand_op(cur_mix));
    end
  endtask

  // hold off until every queued word has gone in and every response is back
  task automatic wait_drained();
    while (op_backlog.size() != 0 || op_valid || rsp_pending.size() != 0)
      @(posedge clk);
  endtask

  // driver: new word or idle at the falling edge, held while not accepted
  always @(negedge clk) begin
    if (rst) begin
      op_valid  <= 1'b0;
      rsp_stall <= 1'b0;
    end else begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
      if (!op_valid || op_taken) begin
        if (op_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
          op_word  <= op_backlog.pop_front();
          op_valid <= 1'b1;
        end else begin
          op_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check responses first, then predict for the accepted op word
  always @(posedge clk) begin
    rsp_word_t exp_w;
    if (rst) begin
      op_taken <= 1'b0;
    end else begin
      op_taken <= op_valid && !op_stall;
      if (rsp_valid && !rsp_stall) begin
        n_checked++;
        if (rsp_pending.size() == 0) begin
          errors++;
          $display("%0t: response expected none got %p", $time, rsp_word);
        end else begin
          exp_w = rsp_pending.pop_front();
          if (exp_w.status !== rsp_word.status) begin
            errors++;
            $display("%0t: status expected %0d got %0d", $time,
                     exp_w.status, rsp_word.status);
          end
          if (exp_w.line_bit !== rsp_word.line_bit) begin
            errors++;
            $display("%0t: line_bit expected %0d got %0d", $time,
                     exp_w.line_bit, rsp_word.line_bit);
          end
          if (exp_w.fill_count !== rsp_word.fill_count) begin
            errors++;
            $display("%0t: fill_count expected %0d got %0d", $time,
                     exp_w.fill_count, rsp_word.fill_count);
          end
        end
      end
      if (op_valid && !op_stall)
        rsp_pending.push_back(apply_op(op_word));
    end
  end

  // stimulus and phase control
  initial begin
    int p;
    int unsigned idle_set [4];
    int unsigned stall_set [4];
    idle_set  = '{0, 71, 0, 17};
    stall_set = '{0, 0, 71, 17};
    for (int i = 0; i < DEPTH; i++) line_store[i] = 1'b0;

    repeat (10) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    // directed: empty pop, spare opcode, clear, byte extremes, pops, ignored data
    queue_op(OP_POP,   8'h5A);
    queue_op(OP_SPARE, 8'hFF);
    queue_op(OP_CLEAR, 8'hFF);
    queue_op(OP_PUSH,  8'h00);
    queue_op(OP_PUSH,  8'hFF);
    queue_op(OP_PUSH,  8'hA5);
    queue_op(OP_PUSH,  8'h80);
    queue_op(OP_PUSH,  8'h01);
    repeat (4) queue_op(OP_POP, 8'hFF);
    queue_op(OP_SPARE, 8'h00);
    queue_op(OP_POP,   8'h00);
    queue_op(OP_CLEAR, 8'h00);
    queue_op(OP_POP,   8'hC3);
    queue_op(OP_PUSH,  8'h3C);
    repeat (3) queue_op(OP_POP, 8'h7E);
    wait_drained();

    for (p = 0; p < 4; p++) begin
      idle_pct  = idle_set[p];
      stall_pct = stall_set[p];
      queue_random(RAND_WORDS);
      wait_drained();
    end

    stall_pct = 0;
    repeat (5) @(posedge clk);
    $display("checked %0d response words over four idle/stall patterns", n_checked);
    $display("pushes %0d, refused %0d, pops %0d, empty pops %0d, clears %0d",
             n_pushed, n_refused, n_popped, n_empty, n_cleared);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
